// ----- src/apn_pkg.sv -----
`timescale 1ns / 1ps
// Package for the absolute path normalizer.
// Holds the opcode and error codes, character constants and port widths.
// No dependencies.
package apn_pkg;

    localparam int MAX_PATH_LEN_DEF = 4096;

    localparam int OPCODE_W = 2;
    localparam int BYTE_W = 8;
    localparam int INDEX_W = 12;
    localparam int LENGTH_W = 13;
    localparam int ERROR_W = 2;

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_DOT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_END = 8'h00;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    typedef enum logic [ERROR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_NOT_ABS  = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_error;

endpackage

// ----- src/absolute_path_normalizer_top.sv -----
`timescale 1ns / 1ps
// Absolute path normalizer, top level.
// Depends on apn_pkg. Holds the path byte store and the segment start stack.
//
// Usage: each input beat carries an opcode. Start clears the path state, append
// takes one path byte (a zero byte ends the path) and read returns one byte of
// the normalized path by index. Every input beat produces exactly one output beat
// with out_byte, norm_length, finished and error_code as they stand after that
// beat.
// Throughput is one beat per cycle in every opcode mix while o_in_stall is low. The accepting
// edge performs the synchronous read of the byte store into the middle stage, and the output
// register is loaded from that stage once the output register is free.
// A ".." segment reads the segment start stack; the top entry is kept in a
// register and the entry below it is forwarded from the stack read port the
// following cycle, so no beat waits on the stack.
// A synchronous active-low reset clears all control state; the two stores are
// not cleared and need no clearing pass. When the receiver stalls, the output
// beat holds and one more beat can be taken into the middle stage before the
// input is stalled in turn.
module absolute_path_normalizer_top
    import apn_pkg::*;
#(
    parameter int MAX_PATH_LEN = MAX_PATH_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [BYTE_W-1:0]   i_in_byte,
    input  logic [INDEX_W-1:0]  i_read_index,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [BYTE_W-1:0]   o_out_byte,
    output logic [LENGTH_W-1:0] o_norm_length,
    output logic                o_finished,
    output logic [ERROR_W-1:0]  o_error_code
);

    localparam int AW = $clog2(MAX_PATH_LEN);
    localparam int PW = $clog2(MAX_PATH_LEN + 2);
    localparam int STACK_MAX = MAX_PATH_LEN / 2;
    localparam int SAW = $clog2(STACK_MAX);
    localparam int SDW = $clog2(STACK_MAX + 1);
    localparam int XW = PW + INDEX_W;

    localparam logic [PW-1:0] MAX_P = PW'(MAX_PATH_LEN);
    localparam logic [XW-1:0] MAX_X = XW'(MAX_PATH_LEN);
    localparam logic [SDW-1:0] STACK_MAX_D = SDW'(STACK_MAX);

    logic [BYTE_W-1:0] path_mem [MAX_PATH_LEN];
    logic [PW-1:0]     stack_mem [STACK_MAX];

    logic [SDW-1:0]    r_depth, n_depth;
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_seg_start, n_seg_start;
    logic [1:0]        r_seg_len, n_seg_len;
    logic [1:0]        r_dots, n_dots;
    logic [PW-1:0]     r_taken, n_taken;
    logic              r_done, n_done;
    t_error            r_err, n_err;
    logic [PW-1:0]     r_top, n_top;
    logic              r_pop_pend, n_pop_pend;

    logic              pw_we;
    logic [AW-1:0]     pw_addr;
    logic [BYTE_W-1:0] pw_data;
    logic              pr_re;
    logic [AW-1:0]     pr_addr;
    logic [BYTE_W-1:0] r_pdata;

    logic              st_we;
    logic [SAW-1:0]    st_waddr;
    logic              st_re;
    logic [SAW-1:0]    st_raddr;
    logic [PW-1:0]     r_st_rdata;

    logic              accept;
    logic              out_free;
    logic              do_end;
    logic              last_seg;
    logic [PW-1:0]     top;
    logic              single_dot;
    logic              double_dot;
    logic              ok;
    logic [PW-1:0]     len;
    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     len_x;

    logic              r_v1;
    logic              r_rdsel1;
    logic [PW-1:0]     r_len1;
    logic              r_fin1;
    t_error            r_err1;

    logic              r_ov;
    logic [BYTE_W-1:0] r_out_byte;
    logic [PW-1:0]     r_out_len;
    logic              r_out_fin;
    t_error            r_out_err;

    assign out_free = !r_ov || !i_out_stall;
    assign o_in_stall = r_v1 && !out_free;
    assign accept = i_in_valid && !o_in_stall;

    assign top = r_pop_pend ? r_st_rdata : r_top;
    assign single_dot = (r_seg_len == 2'd1) && (r_dots == 2'd1);
    assign double_dot = (r_seg_len == 2'd2) && (r_dots == 2'd2);

    always_comb begin
        n_depth = r_depth;
        n_wp = r_wp;
        n_seg_start = r_seg_start;
        n_seg_len = r_seg_len;
        n_dots = r_dots;
        n_taken = r_taken;
        n_done = r_done;
        n_err = r_err;
        n_top = top;
        n_pop_pend = 1'b0;
        pw_we = 1'b0;
        pw_addr = r_wp[AW-1:0];
        pw_data = i_in_byte;
        st_we = 1'b0;
        st_waddr = r_depth[SAW-1:0];
        st_re = 1'b0;
        st_raddr = SAW'(r_depth - SDW'(2));
        do_end = 1'b0;
        last_seg = 1'b0;

        if (accept) begin
            case (t_opcode'(i_opcode))
                OP_START: begin
                    n_depth = '0;
                    n_wp = PW'(1);
                    n_seg_start = PW'(1);
                    n_seg_len = 2'd0;
                    n_dots = 2'd0;
                    n_taken = '0;
                    n_done = 1'b0;
                    n_err = ERR_NONE;
                end
                OP_APPEND: begin
                    if (!r_done) begin
                        if (i_in_byte == CH_END) begin
                            if (r_err == ERR_NONE) begin
                                if (r_taken == '0) begin
                                    n_err = ERR_NOT_ABS;
                                end else begin
                                    do_end = 1'b1;
                                    last_seg = 1'b1;
                                end
                            end
                            n_done = 1'b1;
                        end else if (r_err == ERR_NONE) begin
                            if (r_taken >= MAX_P) begin
                                n_err = ERR_OVERFLOW;
                            end else if (r_taken == '0) begin
                                n_taken = PW'(1);
                                if (i_in_byte != CH_SLASH) begin
                                    n_err = ERR_NOT_ABS;
                                end else begin
                                    pw_we = 1'b1;
                                    pw_addr = '0;
                                    pw_data = CH_SLASH;
                                end
                            end else begin
                                n_taken = r_taken + PW'(1);
                                if (i_in_byte == CH_SLASH) begin
                                    do_end = 1'b1;
                                end else begin
                                    pw_we = (r_wp < MAX_P);
                                    n_wp = r_wp + PW'(1);
                                    if (r_seg_len != 2'd3) begin
                                        n_seg_len = r_seg_len + 2'd1;
                                    end
                                    if (i_in_byte == CH_DOT && r_dots != 2'd3) begin
                                        n_dots = r_dots + 2'd1;
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_end) begin
            if (r_seg_len == 2'd0 || single_dot) begin
                n_wp = r_seg_start;
            end else if (double_dot) begin
                if (r_depth != '0) begin
                    n_depth = r_depth - SDW'(1);
                    n_wp = top;
                    if (r_depth > SDW'(1)) begin
                        st_re = 1'b1;
                        n_pop_pend = 1'b1;
                    end
                end else begin
                    n_wp = PW'(1);
                end
            end else begin
                if (!last_seg && r_wp < MAX_P) begin
                    pw_we = 1'b1;
                    pw_data = CH_SLASH;
                end
                n_wp = r_wp + PW'(1);
                if (r_depth < STACK_MAX_D) begin
                    st_we = 1'b1;
                    n_top = r_seg_start;
                    n_depth = r_depth + SDW'(1);
                end
            end
            n_seg_start = n_wp;
            n_seg_len = 2'd0;
            n_dots = 2'd0;
        end
    end

    always_comb begin
        ok = n_done && (n_err == ERR_NONE);
        len = '0;
        if (ok) begin
            len = (n_wp >= PW'(2)) ? (n_wp - PW'(1)) : PW'(1);
        end
        idx_x = XW'(i_read_index);
        len_x = XW'(len);
        pr_addr = idx_x[AW-1:0];
        pr_re = accept && (t_opcode'(i_opcode) == OP_READ) && ok
            && (idx_x < len_x) && (idx_x < MAX_X);
    end

    always_ff @(posedge i_clk) begin
        if (pw_we) begin
            path_mem[pw_addr] <= pw_data;
        end
        if (pr_re) begin
            r_pdata <= path_mem[pr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            stack_mem[st_waddr] <= r_seg_start;
        end
        if (st_re) begin
            r_st_rdata <= stack_mem[st_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_wp <= PW'(1);
            r_seg_start <= PW'(1);
            r_seg_len <= 2'd0;
            r_dots <= 2'd0;
            r_taken <= '0;
            r_done <= 1'b0;
            r_err <= ERR_NONE;
            r_pop_pend <= 1'b0;
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_wp <= n_wp;
            r_seg_start <= n_seg_start;
            r_seg_len <= n_seg_len;
            r_dots <= n_dots;
            r_taken <= n_taken;
            r_done <= n_done;
            r_err <= n_err;
            r_pop_pend <= n_pop_pend;
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (out_free) begin
                r_v1 <= 1'b0;
            end
            if (out_free) begin
                r_ov <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (accept) begin
            r_rdsel1 <= pr_re;
            r_len1 <= len;
            r_fin1 <= n_done;
            r_err1 <= n_err;
        end
        if (out_free && r_v1) begin
            r_out_byte <= r_rdsel1 ? r_pdata : CH_END;
            r_out_len <= r_len1;
            r_out_fin <= r_fin1;
            r_out_err <= r_err1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_byte = r_out_byte;
    assign o_norm_length = LENGTH_W'(r_out_len);
    assign o_finished = r_out_fin;
    assign o_error_code = r_out_err;

endmodule
